// ----- hw/rtl/pltc_pkg.sv -----
// Shared types and codes for the point light table cull block.
package pltc_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned REACH_W = 23;
  localparam int unsigned ENTRY_W = 3 * COORD_W + 3 * COLOR_W + 2 * REACH_W;
  localparam int unsigned MAX_RES = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RK_ADDED    = 3'd0,
    RK_FULL     = 3'd1,
    RK_REMOVED  = 3'd2,
    RK_NO_SLOT  = 3'd3,
    RK_SELECTED = 3'd4,
    RK_NONE     = 3'd5
  } kind_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [REACH_W-1:0] reach;
    logic [REACH_W-1:0] trigger;
  } entry_t;

endpackage

// ----- hw/rtl/pltc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module pltc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/point_light_table_cull_core.sv -----
// Point light table with distance culling, top level.
// A remove returns its result beat before the next command is accepted. An add scans the active
// bits one slot per cycle up to the high-water mark. An update reads one slot per cycle, unless a
// stalled result beat freezes the scan, into a three-stage distance pipeline and holds each
// selected light until it knows whether another follows.
// Reset is synchronous; the block then clears the active-bit RAM, with no result beat.
module point_light_table_cull_core #(
  parameter int unsigned MAX_LIGHTS     = 64,
  parameter int unsigned FIRST_HW_LIGHT = 0,
  parameter int unsigned END_HW_LIGHT   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [6:0]  slot,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  input  logic [15:0] color_red,
  input  logic [15:0] color_green,
  input  logic [15:0] color_blue,
  input  logic [22:0] light_reach,
  input  logic [22:0] trigger_distance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [5:0]  slot_index,
  output logic [2:0]  hw_light_number,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [22:0] out_reach,
  output logic        last
);

  localparam int unsigned AW = $clog2(MAX_LIGHTS);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] FULL_MARK = CW'(MAX_LIGHTS);
  localparam logic [4:0] HW_FIRST = 5'(FIRST_HW_LIGHT);
  localparam logic [4:0] HW_END   = 5'(END_HW_LIGHT);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_SCAN, S_ADD_WRITE, S_UPD_SCAN, S_UPD_DRAIN,
    S_RESULT, S_NONE_OUT
  } state_t;

  state_t state;
  logic [CW-1:0] mark;
  logic [CW-1:0] ptr;
  logic [1:0]    op;
  logic [6:0]    rm_slot;
  pltc_pkg::entry_t cmd;

  // Active bits live in a 1-bit RAM; light data in a wide RAM.
  logic          act_we, act_wd, act_rd;
  logic [AW-1:0] act_wa, act_ra;
  logic          ent_we;
  logic [AW-1:0] ent_wa, ent_ra;
  pltc_pkg::entry_t ent_rd;

  pltc_ram #(.WIDTH(1), .DEPTH(MAX_LIGHTS)) u_act (
    .clk(clk), .wr_en(act_we), .wr_addr(act_wa), .wr_data(act_wd),
    .rd_addr(act_ra), .rd_data(act_rd));

  pltc_ram #(.WIDTH(pltc_pkg::ENTRY_W), .DEPTH(MAX_LIGHTS)) u_ent (
    .clk(clk), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(cmd),
    .rd_addr(ent_ra), .rd_data(ent_rd));

  // Scan pipeline: stage 1 = RAM read, stage 2 = differences, stage 3 = squares,
  // with the sum and compare done combinationally on stage 3.
  logic          s1_v;
  logic [AW-1:0] s1_idx;
  logic          s2_v;
  logic [AW-1:0] s2_idx;
  logic [24:0]   dx, dy, dz;
  pltc_pkg::entry_t s2_e;
  logic          s3_v;
  logic [AW-1:0] s3_idx;
  logic [49:0]   qx, qy, qz;
  logic [45:0]   qt;
  pltc_pkg::entry_t s3_e;
  logic [51:0]   dsum;
  logic          hit;
  logic [4:0]    hw;
  logic [3:0]    nres;
  logic          stop;
  logic          pipe_busy;

  // The newest selected light waits here until the scan shows whether it is the last one.
  logic          pend_v;
  logic [AW-1:0] pend_idx;
  logic [2:0]    pend_hw;
  pltc_pkg::entry_t pend_e;

  logic          hold;
  logic          upd_run;
  logic          take_hit;
  logic          scan_done;

  assign dsum = 52'(qx) + 52'(qy) + 52'(qz);
  assign hit  = s3_v && (dsum < 52'(qt));
  assign pipe_busy = s1_v || s2_v || s3_v;

  // A result beat that is stalled freezes the whole update scan.
  assign hold      = out_valid && out_stall;
  assign upd_run   = (state == S_UPD_SCAN || state == S_UPD_DRAIN) && !hold;
  assign take_hit  = hit && !stop;
  assign scan_done = (state == S_UPD_DRAIN) && (stop || !pipe_busy);

  function automatic logic [24:0] absdiff(input logic [23:0] a, input logic [23:0] b);
    logic signed [24:0] d;
    d = 25'($signed(a)) - 25'($signed(b));
    return d[24] ? 25'(-d) : 25'(d);
  endfunction

  // While frozen, the RAMs keep reading the stage 1 slot so its data stays in place.
  assign act_ra = hold ? s1_idx : ptr[AW-1:0];
  assign ent_ra = hold ? s1_idx : ptr[AW-1:0];

  always_comb begin
    act_we = 1'b0;
    act_wa = ptr[AW-1:0];
    act_wd = 1'b0;
    ent_we = 1'b0;
    ent_wa = ptr[AW-1:0];
    unique case (state)
      S_CLEAR: act_we = 1'b1;
      S_ADD_WRITE: begin
        act_we = 1'b1;
        act_wd = 1'b1;
        ent_we = 1'b1;
      end
      S_IDLE: begin
        if (in_valid && operation == pltc_pkg::OP_REMOVE && 8'(slot) < 8'(mark)) begin
          act_we = 1'b1;
          act_wa = slot[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      mark <= '0;
      ptr <= '0;
      out_valid <= 1'b0;
      s1_v <= 1'b0;
      s1_idx <= '0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      stop <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (!hold) begin
        s2_v <= s1_v && !stop;
        s3_v <= s2_v && !stop;
        s1_v <= 1'b0;
        s2_idx <= s1_idx;
        s2_e <= ent_rd;
        dx <= absdiff(ent_rd.x, cmd.x);
        dy <= absdiff(ent_rd.y, cmd.y);
        dz <= absdiff(ent_rd.z, cmd.z);
        s3_idx <= s2_idx;
        s3_e <= s2_e;
        qx <= dx * dx;
        qy <= dy * dy;
        qz <= dz * dz;
        qt <= s2_e.trigger * s2_e.trigger;
      end
      unique case (state)
        S_CLEAR: begin
          if (ptr == FULL_MARK - 1'b1) begin
            ptr <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op <= operation;
            rm_slot <= slot;
            cmd <= '{point_x, point_y, point_z, color_red, color_green, color_blue,
                     light_reach, trigger_distance};
            ptr <= '0;
            hw <= HW_FIRST;
            nres <= '0;
            stop <= 1'b0;
            unique case (operation)
              pltc_pkg::OP_ADD:    state <= S_ADD_SCAN;
              pltc_pkg::OP_REMOVE: state <= S_RESULT;
              pltc_pkg::OP_UPDATE: state <= S_UPD_SCAN;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_ADD_SCAN: begin
          // ptr addresses the RAM; the read for ptr arrives next cycle.
          if (s1_v && !act_rd) begin
            ptr <= {1'b0, s1_idx};
            state <= S_ADD_WRITE;
          end else if (ptr >= mark) begin
            if (!s1_v) begin
              if (mark == FULL_MARK) begin
                state <= S_RESULT;
              end else begin
                ptr <= mark;
                mark <= mark + 1'b1;
                state <= S_ADD_WRITE;
              end
            end
          end else begin
            s1_v <= 1'b1;
            s1_idx <= ptr[AW-1:0];
            ptr <= ptr + 1'b1;
          end
        end
        S_ADD_WRITE: state <= S_RESULT;
        S_UPD_SCAN: begin
          if (!hold) begin
            if (!stop && ptr < mark) begin
              s1_v <= 1'b1;
              s1_idx <= ptr[AW-1:0];
              ptr <= ptr + 1'b1;
            end else if (!pipe_busy || stop) begin
              state <= S_UPD_DRAIN;
            end
          end
        end
        default: ;
      endcase
      if (upd_run) begin
        // The active bit rides along with stage 1 data.
        if (s1_v && !act_rd) s2_v <= 1'b0;
        // A held selection goes out once a later one arrives or the scan is over;
        // only the one sent at the end of the scan is the last beat.
        if (pend_v && (take_hit || scan_done)) begin
          out_valid <= 1'b1;
          result_kind <= pltc_pkg::RK_SELECTED;
          slot_index <= 6'(pend_idx);
          hw_light_number <= pend_hw;
          out_x <= pend_e.x;
          out_y <= pend_e.y;
          out_z <= pend_e.z;
          out_red <= pend_e.red;
          out_green <= pend_e.green;
          out_blue <= pend_e.blue;
          out_reach <= pend_e.reach;
          last <= scan_done;
        end
        if (take_hit) begin
          pend_v <= 1'b1;
          pend_idx <= s3_idx;
          pend_hw <= hw[2:0];
          pend_e <= s3_e;
          hw <= hw + 1'b1;
          nres <= nres + 1'b1;
          // Hardware numbers or result slots ran out: nothing after this one.
          if (hw + 1'b1 >= HW_END || nres + 1'b1 >= 4'(pltc_pkg::MAX_RES)) begin
            stop <= 1'b1;
          end
        end
        if (scan_done) begin
          pend_v <= 1'b0;
          state <= pend_v ? S_IDLE : S_NONE_OUT;
        end
      end
      if (state == S_RESULT) begin
        out_valid <= 1'b1;
        last <= 1'b1;
        hw_light_number <= '0;
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
        out_red <= '0;
        out_green <= '0;
        out_blue <= '0;
        out_reach <= '0;
        state <= S_IDLE;
        if (op == pltc_pkg::OP_ADD) begin
          result_kind <= (ptr == FULL_MARK) ? pltc_pkg::RK_FULL : pltc_pkg::RK_ADDED;
          slot_index <= (ptr == FULL_MARK) ? 6'd0 : 6'(ptr);
        end else if (8'(rm_slot) < 8'(mark)) begin
          result_kind <= pltc_pkg::RK_REMOVED;
          slot_index <= 6'(rm_slot);
        end else begin
          result_kind <= pltc_pkg::RK_NO_SLOT;
          slot_index <= '0;
        end
      end
      if (state == S_NONE_OUT) begin
        out_valid <= 1'b1;
        last <= 1'b1;
        result_kind <= pltc_pkg::RK_NONE;
        slot_index <= '0;
        hw_light_number <= '0;
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
        out_red <= '0;
        out_green <= '0;
        out_blue <= '0;
        out_reach <= '0;
        state <= S_IDLE;
      end
    end
  end

`ifndef SYNTHESIS
  a_mark_bound: assert property (@(posedge clk) disable iff (rst) mark <= FULL_MARK)
    else $error("mark past table size");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall) else $error("accept during clear");
  a_mark_mono: assert property (@(posedge clk) disable iff (rst)
    $past(state) != S_CLEAR && !$past(rst) |-> mark >= $past(mark))
    else $error("mark went down");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(slot_index)
      && $stable(last) && $stable(out_x))
    else $error("stalled result beat changed");
`endif

endmodule
